// ===== rtl/lfsc_pkg.sv =====
// shared types, constants and the crc byte fold for the little-endian field serializer
// used by lfsc_front, lfsc_back and le_field_serializer_crc32_top; no dependencies
package lfsc_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
  localparam int unsigned TRAILER_BYTES = 4;

  typedef enum logic [0:0] {
    REG_FRAME_LEN = 1'b0,
    REG_CAPACITY  = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BODY,
    ST_TRAIL
  } back_state_e;

  // input item as seen on the port
  typedef struct packed {
    logic [63:0] field_value;
    logic [1:0]  field_size;
    logic        last_field;
  } in_t;

  // result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
    logic       size_error;
  } out_t;

  // classified item held in the queue between front and back
  typedef struct packed {
    logic [63:0] data;
    logic [2:0]  last_idx;
    logic        last;
  } work_t;

  // queue head handshake toward the back end
  typedef struct packed {
    logic  valid;
    work_t item;
  } q_head_t;

  // configuration seen by the back end
  typedef struct packed {
    logic [15:0] frame_len;
    logic        cap_ok;
  } cfg_t;

  function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

// ===== rtl/lfsc_front.sv =====
// front end: accepts input items, turns the size code into a last byte index,
// and holds them in a two-entry queue; depends on lfsc_pkg
module lfsc_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  lfsc_pkg::in_t   in_data_i,
  output lfsc_pkg::q_head_t head_o,
  input  logic            pop_i
);

  lfsc_pkg::work_t entries_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      fill_q, fill_d;
  logic            push;
  logic            pop;
  lfsc_pkg::work_t new_item;

  assign in_stall_o = (fill_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = pop_i && (fill_q != 2'd0);

  // size code to index of the last byte: 1, 2, 4 or 8 bytes
  always_comb begin
    new_item.data     = in_data_i.field_value;
    new_item.last     = in_data_i.last_field;
    case (in_data_i.field_size)
      2'd0:    new_item.last_idx = 3'd0;
      2'd1:    new_item.last_idx = 3'd1;
      2'd2:    new_item.last_idx = 3'd3;
      default: new_item.last_idx = 3'd7;
    endcase
  end

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= new_item;
    end
  end

  assign head_o.valid = (fill_q != 2'd0);
  assign head_o.item  = entries_q[rd_ptr_q];

endmodule

// ===== rtl/lfsc_back.sv =====
// back end: emits one byte per cycle unless stalled, folds body bytes into the
// crc, counts them, runs the record checks, appends the trailer; depends on lfsc_pkg
module lfsc_back #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lfsc_pkg::cfg_t    cfg_i,
  input  lfsc_pkg::q_head_t head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output lfsc_pkg::out_t    out_data_o
);

  localparam int unsigned SW = ((LENGTH_BITS > 16) ? LENGTH_BITS : 16) + 1;

  lfsc_pkg::back_state_e state_q, state_d;
  logic [63:0]           data_q, data_d;
  logic [2:0]            last_idx_q, last_idx_d;
  logic                  last_q, last_d;
  logic [2:0]            idx_q, idx_d;
  logic [1:0]            tidx_q, tidx_d;
  logic [31:0]           crc_q, crc_d;
  logic [LENGTH_BITS-1:0] cnt_q, cnt_d;
  logic [31:0]           fin_q, fin_d;
  logic                  ovalid_q, ovalid_d;
  lfsc_pkg::out_t        obuf_q, obuf_d;

  logic                  adv;
  logic [7:0]            body_byte;
  logic [31:0]           crc_next;
  logic [LENGTH_BITS-1:0] cnt_next;
  logic                  len_ok;
  logic                  take_next;

  assign adv       = !ovalid_q || !out_stall_i;
  assign body_byte = data_q[{idx_q, 3'b000} +: 8];
  assign crc_next  = lfsc_pkg::crc_fold(crc_q, body_byte);
  assign cnt_next  = (cnt_q == {LENGTH_BITS{1'b1}}) ? cnt_q : cnt_q + LENGTH_BITS'(1);
  // saturated count never passes
  assign len_ok    = (cnt_next != {LENGTH_BITS{1'b1}}) &&
                     ((SW'(cnt_next) + SW'(lfsc_pkg::TRAILER_BYTES)) ==
                      SW'(cfg_i.frame_len));

  always_comb begin
    state_d    = state_q;
    data_d     = data_q;
    last_idx_d = last_idx_q;
    last_d     = last_q;
    idx_d      = idx_q;
    tidx_d     = tidx_q;
    crc_d      = crc_q;
    cnt_d      = cnt_q;
    fin_d      = fin_q;
    ovalid_d   = ovalid_q && out_stall_i;
    obuf_d     = obuf_q;
    take_next  = 1'b0;

    case (state_q)
      lfsc_pkg::ST_IDLE: begin
        take_next = 1'b1;
      end
      lfsc_pkg::ST_BODY: begin
        if (adv) begin
          ovalid_d          = 1'b1;
          obuf_d.out_byte   = body_byte;
          obuf_d.last_byte  = 1'b0;
          obuf_d.size_error = 1'b0;
          crc_d             = crc_next;
          cnt_d             = cnt_next;
          idx_d             = idx_q + 3'd1;
          if (idx_q == last_idx_q) begin
            if (last_q) begin
              crc_d = lfsc_pkg::CRC_INIT;
              cnt_d = '0;
              if (len_ok && cfg_i.cap_ok) begin
                fin_d   = ~crc_next;
                tidx_d  = 2'd0;
                state_d = lfsc_pkg::ST_TRAIL;
              end else begin
                obuf_d.last_byte  = 1'b1;
                obuf_d.size_error = 1'b1;
                take_next         = 1'b1;
              end
            end else begin
              take_next = 1'b1;
            end
          end
        end
      end
      lfsc_pkg::ST_TRAIL: begin
        if (adv) begin
          ovalid_d          = 1'b1;
          obuf_d.out_byte   = fin_q[{tidx_q, 3'b000} +: 8];
          obuf_d.last_byte  = (tidx_q == 2'd3);
          obuf_d.size_error = 1'b0;
          tidx_d            = tidx_q + 2'd1;
          if (tidx_q == 2'd3) begin
            take_next = 1'b1;
          end
        end
      end
      default: begin
        state_d = lfsc_pkg::ST_IDLE;
      end
    endcase

    // load the next queued item as the current one finishes
    if (take_next) begin
      if (head_i.valid) begin
        data_d     = head_i.item.data;
        last_idx_d = head_i.item.last_idx;
        last_d     = head_i.item.last;
        idx_d      = 3'd0;
        state_d    = lfsc_pkg::ST_BODY;
      end else begin
        state_d = lfsc_pkg::ST_IDLE;
      end
    end
  end

  assign pop_o = take_next && head_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= lfsc_pkg::ST_IDLE;
      idx_q    <= 3'd0;
      tidx_q   <= 2'd0;
      crc_q    <= lfsc_pkg::CRC_INIT;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      tidx_q   <= tidx_d;
      crc_q    <= crc_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q     <= data_d;
    last_idx_q <= last_idx_d;
    last_q     <= last_d;
    fin_q      <= fin_d;
    obuf_q     <= obuf_d;
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = obuf_q;

endmodule

// ===== rtl/le_field_serializer_crc32_top.sv =====
// top level of the little-endian field serializer with crc-32 trailer
// depends on lfsc_pkg, lfsc_front and lfsc_back
//
// Each input item carries one record field of 1, 2, 4 or 8 bytes. The block
// emits the field's bytes least significant first, one result item per clock
// unless the output stalls, folding each into a reflected crc-32 (poly
// 0xEDB88320, init all ones) and counting body bytes with a saturating counter
// of LENGTH_BITS bits. On the field marked last it checks an unsaturated count,
// body length + 4 == frame length and capacity >= frame length; if all hold
// the inverted crc follows as four bytes, least significant first, the last
// flagged last_byte; otherwise the field's final byte carries last_byte and
// size_error and no trailer follows. The crc and count then restart. Bytes
// go out one at a time; the single-byte output path sets the rate. A queue of
// two entries before the emitter keeps input accepted while results stall,
// until both fill, and an output register holds the result being offered.
// Configuration is a plain write port: index 0 is the expected frame length in
// bytes including the trailer, index 1 is capacity; write only while the block
// is idle.
module le_field_serializer_crc32_top #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  // configuration write port
  input  logic           cfg_we_i,
  input  logic [0:0]     cfg_idx_i,
  input  logic [15:0]    cfg_wdata_i,
  // input items
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  lfsc_pkg::in_t  in_data_i,
  // result items
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output lfsc_pkg::out_t out_data_o
);

  logic [15:0]       frame_len_q;
  logic [15:0]       capacity_q;
  lfsc_pkg::cfg_t    cfg;
  lfsc_pkg::q_head_t head;
  logic              pop;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_len_q <= 16'd0;
      capacity_q  <= 16'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lfsc_pkg::REG_FRAME_LEN: frame_len_q <= cfg_wdata_i;
        lfsc_pkg::REG_CAPACITY:  capacity_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // capacity compare depends only on configuration, so it is settled here
  assign cfg.frame_len = frame_len_q;
  assign cfg.cap_ok    = (capacity_q >= frame_len_q);

  // front: accept and classify items into the queue
  lfsc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .head_o     (head),
    .pop_i      (pop)
  );

  // back: byte emitter, crc, count, checks and trailer
  lfsc_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== tb/le_field_serializer_crc32_top_tb.sv =====
// self-checking testbench for le_field_serializer_crc32_top: byte order, crc-32 trailer,
// length and capacity checks, count saturation; depends on lfsc_pkg and the rtl top only
`timescale 1ns / 1ps

module le_field_serializer_crc32_top_tb;

  // field size codes as carried in field_size
  localparam logic [1:0] SZ_BYTE  = 2'd0;
  localparam logic [1:0] SZ_HALF  = 2'd1;
  localparam logic [1:0] SZ_WORD  = 2'd2;
  localparam logic [1:0] SZ_DWORD = 2'd3;

  // a narrow byte counter keeps the saturation records short
  localparam int unsigned LENGTH_BITS = 8;
  localparam logic [15:0] CNT_MAX     = 16'((1 << LENGTH_BITS) - 1);

  localparam int unsigned RANDOM_ITEMS = 210;

  // expected byte stream of the framer: tracks crc and body length, queues the
  // bytes each accepted field must produce and checks results against them
  class framer_scoreboard;
    logic [15:0]    frame_len;
    logic [15:0]    capacity;
    logic [31:0]    crc;
    logic [15:0]    body_len;
    lfsc_pkg::out_t expected_bytes[$];
    int             errors;
    int             fields_seen;
    int             bytes_checked;
    int             records_framed;
    int             records_flagged;

    function new();
      frame_len = '0;
      capacity  = '0;
      crc       = lfsc_pkg::CRC_INIT;
      body_len  = '0;
      errors    = 0;
    endfunction

    function void set_reg(lfsc_pkg::reg_idx_e idx, logic [15:0] val);
      if (idx == lfsc_pkg::REG_FRAME_LEN) begin
        frame_len = val;
      end else begin
        capacity = val;
      end
    endfunction

    // bit-serial reflected crc, one data bit per step
    function logic [31:0] crc_step(logic [31:0] c, logic [7:0] d);
      for (int k = 0; k < 8; k++) begin
        if (c[0] ^ d[k]) begin
          c = (c >> 1) ^ lfsc_pkg::CRC_POLY;
        end else begin
          c = c >> 1;
        end
      end
      return c;
    endfunction

    function void note_field(lfsc_pkg::in_t f);
      lfsc_pkg::out_t frame[$];
      lfsc_pkg::out_t b;
      int             nbytes;
      logic [31:0]    fcs;
      logic           ok;
      nbytes = 1 << f.field_size;
      fields_seen++;
      for (int i = 0; i < nbytes; i++) begin
        b.out_byte   = f.field_value[8*i +: 8];
        b.last_byte  = 1'b0;
        b.size_error = 1'b0;
        crc = crc_step(crc, b.out_byte);
        if (body_len != CNT_MAX) begin
          body_len++;
        end
        frame.push_back(b);
      end
      if (f.last_field) begin
        // a saturated count only means "at least", so it can never match
        ok = (body_len != CNT_MAX) &&
             ({1'b0, body_len} + 17'd4 == {1'b0, frame_len}) &&
             (capacity >= frame_len);
        if (ok) begin
          fcs = ~crc;
          for (int i = 0; i < 4; i++) begin
            b.out_byte   = fcs[8*i +: 8];
            b.last_byte  = (i == 3);
            b.size_error = 1'b0;
            frame.push_back(b);
          end
          records_framed++;
        end else begin
          frame[frame.size()-1].last_byte  = 1'b1;
          frame[frame.size()-1].size_error = 1'b1;
          records_flagged++;
        end
        crc      = lfsc_pkg::CRC_INIT;
        body_len = '0;
      end
      foreach (frame[i]) expected_bytes.push_back(frame[i]);
    endfunction

    function void check_byte(lfsc_pkg::out_t got);
      lfsc_pkg::out_t want;
      if (expected_bytes.size() == 0) begin
        $error("unexpected item: out_byte %02h last_byte %0b size_error %0b",
               got.out_byte, got.last_byte, got.size_error);
        errors++;
        return;
      end
      want = expected_bytes.pop_front();
      bytes_checked++;
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
        errors++;
      end
      if (got.last_byte !== want.last_byte) begin
        $error("last_byte: expected %0b, got %0b", want.last_byte, got.last_byte);
        errors++;
      end
      if (got.size_error !== want.size_error) begin
        $error("size_error: expected %0b, got %0b", want.size_error, got.size_error);
        errors++;
      end
    endfunction

    function int outstanding();
      return expected_bytes.size();
    endfunction
  endclass

  logic           clk_i;
  logic           rst_ni;
  logic           cfg_we_i;
  logic [0:0]     cfg_idx_i;
  logic [15:0]    cfg_wdata_i;
  logic           in_valid_i;
  logic           in_stall_o;
  lfsc_pkg::in_t  in_data_i;
  logic           out_valid_o;
  logic           out_stall_i;
  lfsc_pkg::out_t out_data_o;

  framer_scoreboard book = new();

  // idling switches for the sender and the receiver
  bit in_idling;
  bit out_idling;
  int fields_sent;

  le_field_serializer_crc32_top #(
    .LENGTH_BITS (LENGTH_BITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // generous cap: the slowest legal run is well under a quarter of this
  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

  // both handshakes are sampled at the rising edge, before the dut updates
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) book.note_field(in_data_i);
      if (out_valid_o && !out_stall_i) book.check_byte(out_data_o);
    end
  end

  // receiver: random stall bursts while idling is on
  initial begin
    int stall_left;
    stall_left  = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (out_idling && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic lfsc_pkg::in_t field_item(logic [63:0] val, logic [1:0] code,
                                               logic last);
    lfsc_pkg::in_t f;
    f.field_value = val;
    f.field_size  = code;
    f.last_field  = last;
    return f;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // present one item and hold it until accepted; valid stays high into the
  // next item unless an idle gap is drawn
  task automatic send_field(lfsc_pkg::in_t f);
    int gap;
    if (in_idling && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 19);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= f;
    do @(posedge clk_i); while (in_stall_o);
    fields_sent++;
  endtask

  // stop sending and wait for every queued byte to come out
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (book.outstanding() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(lfsc_pkg::reg_idx_e idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    book.set_reg(idx, val);
  endtask

  task automatic configure(logic [15:0] rec_size, logic [15:0] cap);
    wait_drained();
    write_reg(lfsc_pkg::REG_FRAME_LEN, rec_size);
    write_reg(lfsc_pkg::REG_CAPACITY, cap);
  endtask

  // body of nbytes in random field sizes and contents, last flag on the final field
  task automatic send_body(int nbytes);
    int       left;
    int       code;
    left = nbytes;
    while (left > 0) begin
      code = $urandom_range(0, 3);
      while ((1 << code) > left) code--;
      left -= (1 << code);
      send_field(field_item(rand64(), code[1:0], left == 0));
    end
  endtask

  initial begin
    int          random_end;
    int          nrec;
    int          pick;
    logic [15:0] rs;
    logic [15:0] cap;

    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    in_idling   = 1'b1;
    out_idling  = 1'b1;
    fields_sent = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: pass with capacity exactly equal to record size, mixed sizes
    configure(16'd12, 16'd12);
    send_field(field_item(64'h0, SZ_BYTE, 1'b0));
    send_field(field_item({64{1'b1}}, SZ_BYTE, 1'b0));
    send_field(field_item(64'hA5A5_A5A5_A5A5_5A5A, SZ_HALF, 1'b0));
    send_field(field_item(64'h0123_4567_89AB_CDEF, SZ_WORD, 1'b1));
    // single eight-byte fields, all ones and all zeros
    send_field(field_item({64{1'b1}}, SZ_DWORD, 1'b1));
    send_field(field_item(64'h0, SZ_DWORD, 1'b1));
    // body too short for the record size
    send_field(field_item(64'hFFFF_FFFF_0000_0000, SZ_WORD, 1'b1));
    // body too long, spread across non-last fields first
    send_field(field_item(64'h5555_5555_5555_5555, SZ_DWORD, 1'b0));
    send_field(field_item(64'hAAAA_AAAA_AAAA_AAAA, SZ_HALF, 1'b1));

    // capacity one short of the record
    configure(16'd12, 16'd11);
    send_field(field_item(64'hDEAD_BEEF_CAFE_F00D, SZ_DWORD, 1'b1));
    // capacity zero
    configure(16'd12, 16'd0);
    send_field(field_item(64'h8000_0000_0000_0001, SZ_DWORD, 1'b1));

    // record sizes of four or less can never pass
    configure(16'd0, 16'hFFFF);
    send_field(field_item(64'hFF, SZ_BYTE, 1'b1));
    configure(16'd3, 16'hFFFF);
    send_field(field_item(64'h7F, SZ_BYTE, 1'b1));
    configure(16'd4, 16'hFFFF);
    send_field(field_item(64'h80, SZ_BYTE, 1'b1));
    // smallest passing record: one body byte
    configure(16'd5, 16'd5);
    send_field(field_item(64'hFFFF_FFFF_FFFF_FF00, SZ_BYTE, 1'b1));

    // longest body the counter can still match, then a body that saturates it
    configure(CNT_MAX + 16'd3, CNT_MAX + 16'd3);
    repeat (31) send_field(field_item(rand64(), SZ_DWORD, 1'b0));
    send_field(field_item(rand64(), SZ_WORD, 1'b0));
    send_field(field_item(rand64(), SZ_HALF, 1'b1));
    repeat (31) send_field(field_item(rand64(), SZ_DWORD, 1'b0));
    send_field(field_item(rand64(), SZ_DWORD, 1'b1));

    // random phases: each picks a configuration and sends whole records,
    // mostly with the matching body length
    random_end = fields_sent + RANDOM_ITEMS;
    while (fields_sent < random_end) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        rs  = 16'($urandom_range(0, 4));
        cap = 16'($urandom_range(0, 65535));
      end else if (pick == 1) begin
        rs  = 16'($urandom_range(5, 40));
        cap = 16'(rs - $urandom_range(1, rs));
      end else begin
        rs  = 16'($urandom_range(5, 40));
        cap = ($urandom_range(0, 2) == 0) ? rs : 16'($urandom_range(rs, 65535));
      end
      configure(rs, cap);
      nrec = $urandom_range(2, 6);
      repeat (nrec) begin
        // last stretch runs flat out on both sides
        if (random_end - fields_sent < 50) begin
          in_idling  = 1'b0;
          out_idling = 1'b0;
        end
        if (rs >= 5 && $urandom_range(0, 4) != 0) begin
          send_body(rs - 4);
        end else begin
          send_body($urandom_range(1, 40));
        end
        // now and then the sender holds off until the output side has caught up
        if ($urandom_range(0, 9) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);

    $display("run covered %0d fields and %0d output bytes: %0d records with crc trailer,",
             book.fields_seen, book.bytes_checked, book.records_framed);
    $display("%0d records flagged with size error, including count saturation",
             book.records_flagged);
    if (book.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
